// ----- hw/rtl/rre_pkg.sv -----
`default_nettype none

package rre_pkg;

   localparam int SampleWidth = 16;
   localparam int RtoWidth    = 16;
   localparam int CountWidth  = 8;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 16;

   localparam logic [1:0] MODE_NEW_PACKET = 2'd0;
   localparam logic [1:0] MODE_SAMPLE     = 2'd1;
   localparam logic [1:0] MODE_TIMEOUT    = 2'd2;
   localparam logic [1:0] MODE_QUERY      = 2'd3;

   localparam logic [CsrIdxWidth-1:0] CSR_RTO_MIN         = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RTO_MAX         = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_RETRANSMITS = 2'd2;

   localparam logic [RtoWidth-1:0]   RTO_MIN_RESET  = 16'd1000;
   localparam logic [RtoWidth-1:0]   RTO_MAX_RESET  = 16'd3000;
   localparam logic [CountWidth-1:0] MAX_RETX_RESET = 8'd12;
   localparam logic [RtoWidth-1:0]   SRTT_RESET     = 16'd0;
   localparam logic [RtoWidth-1:0]   DEV_RESET      = 16'd750;
   localparam logic [RtoWidth-1:0]   RTO_RESET      = 16'd3000;
   localparam logic [CountWidth-1:0] COUNT_RESET    = 8'd0;

   typedef struct packed {
      logic [1:0]             mode;
      logic [SampleWidth-1:0] sample_ms;
   } req_type;

   typedef struct packed {
      logic [RtoWidth-1:0]   rto_ms;
      logic                  give_up;
      logic [CountWidth-1:0] retransmit_count;
   } rsp_type;

   typedef struct packed {
      logic [RtoWidth-1:0]   rto_min;
      logic [RtoWidth-1:0]   rto_max;
      logic [CountWidth-1:0] max_retransmits;
   } cfg_type;

   typedef struct packed {
      logic [RtoWidth-1:0]   smoothed_rtt;
      logic [RtoWidth-1:0]   rtt_deviation;
      logic [RtoWidth-1:0]   current_rto;
      logic [CountWidth-1:0] retry_count;
   } est_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/rre_csr.sv -----
`default_nettype none

module rre_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rre_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [rre_pkg::CsrDataWidth-1:0]   csr_data,
   output rre_pkg::cfg_type                        cfg
);
   import rre_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RTO_MIN: cfg_in.rto_min = csr_data;
            CSR_RTO_MAX: cfg_in.rto_max = csr_data;
            CSR_MAX_RETRANSMITS: cfg_in.max_retransmits = csr_data[CountWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rto_min         <= RTO_MIN_RESET;
         cfg_ff.rto_max         <= RTO_MAX_RESET;
         cfg_ff.max_retransmits <= MAX_RETX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rre_update.sv -----
`default_nettype none

module rre_update (
   input  rre_pkg::req_type        item,
   input  rre_pkg::cfg_type        cfg,
   input  rre_pkg::est_state_type  cur,
   output rre_pkg::est_state_type  nxt,
   output rre_pkg::rsp_type        result
);
   import rre_pkg::*;

   // The lower limit is tested first; inverted limits give lo below lo, else hi.
   function automatic logic [RtoWidth-1:0] clamp_rto(
      input logic [RtoWidth+1:0] v,
      input logic [RtoWidth-1:0] lo,
      input logic [RtoWidth-1:0] hi
   );
      logic [RtoWidth-1:0] r;
      if (v < {2'b00, lo}) begin
         r = lo;
      end else if (v > {2'b00, hi}) begin
         r = hi;
      end else begin
         r = v[RtoWidth-1:0];
      end
      return r;
   endfunction

   logic signed [RtoWidth:0]   delta;
   logic signed [RtoWidth:0]   srtt_adj;
   logic signed [RtoWidth:0]   srtt_sum;
   logic        [RtoWidth:0]   mag;
   logic signed [RtoWidth+1:0] dev_diff;
   logic signed [RtoWidth+1:0] dev_adj;
   logic signed [RtoWidth+1:0] dev_sum;
   logic        [RtoWidth-1:0] srtt_new;
   logic        [RtoWidth-1:0] dev_new;
   logic        [RtoWidth+1:0] rto_raw;
   logic        [RtoWidth+1:0] rto_dbl;
   logic        [CountWidth-1:0] count_inc;

   always_comb begin
      delta    = $signed({1'b0, item.sample_ms}) - $signed({1'b0, cur.smoothed_rtt});
      srtt_adj = delta >>> 3;
      srtt_sum = $signed({1'b0, cur.smoothed_rtt}) + srtt_adj;
      srtt_new = srtt_sum[RtoWidth-1:0];
      mag      = delta[RtoWidth] ? (RtoWidth+1)'(0) - delta : delta;
      dev_diff = $signed({1'b0, mag}) - $signed({2'b00, cur.rtt_deviation});
      dev_adj  = dev_diff >>> 2;
      dev_sum  = $signed({2'b00, cur.rtt_deviation}) + dev_adj;
      dev_new  = dev_sum[RtoWidth-1:0];
      rto_raw  = {2'b00, srtt_new} + {dev_new, 2'b00};
      rto_dbl  = {1'b0, cur.current_rto, 1'b0};
      count_inc = (cur.retry_count == '1) ? cur.retry_count
                                          : cur.retry_count + CountWidth'(1);

      nxt            = cur;
      result.give_up = 1'b0;
      case (item.mode)
         MODE_NEW_PACKET: begin
            nxt.retry_count = COUNT_RESET;
         end
         MODE_SAMPLE: begin
            nxt.smoothed_rtt  = srtt_new;
            nxt.rtt_deviation = dev_new;
            nxt.current_rto   = clamp_rto(rto_raw, cfg.rto_min, cfg.rto_max);
         end
         MODE_TIMEOUT: begin
            nxt.current_rto = clamp_rto(rto_dbl, cfg.rto_min, cfg.rto_max);
            nxt.retry_count = count_inc;
            result.give_up  = (count_inc > cfg.max_retransmits);
         end
         default: begin
            nxt = cur;
         end
      endcase
      result.rto_ms           = nxt.current_rto;
      result.retransmit_count = nxt.retry_count;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rtt_estimator_rto_timer.sv -----
`default_nettype none

// RTT estimator and retransmission timer (Jacobson/Karels). Each request transaction is one
// event: new packet (mode 0) clears the retransmit count, an RTT sample (mode 1) updates the
// smoothed RTT and mean deviation and recomputes the RTO as srtt + 4*dev, a timeout (mode 2)
// doubles the RTO and counts a retransmission, and a query (mode 3) only reports. Every
// request yields exactly one response transaction carrying the clamped RTO, the retransmit
// count and a give-up flag. An event is registered on input, evaluated combinationally against
// the estimator state and registered on output, and a new request is taken every cycle while
// the response is not stalled; the estimator state is updated as each event leaves the input
// register, which is what lets back-to-back events see each other. Limit writes through the
// CSR port take effect at the next sample or timeout and should be made while idle.
module rtt_estimator_rto_timer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  rre_pkg::req_type                        req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output rre_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rre_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [rre_pkg::CsrDataWidth-1:0]   csr_data
);
   import rre_pkg::*;

   cfg_type       cfg;
   req_type       item_ff;
   logic          item_valid_ff;
   logic          item_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   est_state_type state_ff;
   est_state_type state_in;
   est_state_type state_next;
   logic          advance;

   rre_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rre_update u_update (
      .item   (item_ff),
      .cfg    (cfg),
      .cur    (state_ff),
      .nxt    (state_next),
      .result (rsp_in)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      state_in = advance ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff          <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         state_ff.smoothed_rtt  <= SRTT_RESET;
         state_ff.rtt_deviation <= DEV_RESET;
         state_ff.current_rto   <= RTO_RESET;
         state_ff.retry_count   <= COUNT_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> req_ready)
      else $error("request stalled with an empty input register");

   a_new_packet_clears: assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.mode == MODE_NEW_PACKET |=> rsp_ff.retransmit_count == COUNT_RESET)
      else $error("new packet did not clear the retransmit count");

   a_give_up_timeout_only: assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.mode != MODE_TIMEOUT |=> !rsp_ff.give_up)
      else $error("give-up raised by an event other than a timeout");

   a_query_keeps_rto: assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.mode == MODE_QUERY |=> rsp_ff.rto_ms == $past(state_ff.current_rto))
      else $error("query changed the RTO");

   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_ff.rto_ms == state_ff.current_rto
                  && rsp_ff.retransmit_count == state_ff.retry_count)
      else $error("response disagrees with the updated estimator state");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
   import rre_pkg::*;

   localparam logic [CsrIdxWidth-1:0] CSR_SPARE = 2'd3;
   localparam int StallPercent  = 28;
   localparam int WatchdogLimit = 1000;
   localparam int DrainCycles   = 4;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data  = '0;

   req_type event_queue[$];
   rsp_type report_queue[$];
   logic    req_taken   = 1'b0;
   logic    no_stalls   = 1'b0;
   int      errors      = 0;
   int      quiet_cycles = 0;

   // Shadow of the estimator state and the limit registers.
   logic [RtoWidth-1:0]   srtt;
   logic [RtoWidth-1:0]   dev;
   logic [RtoWidth-1:0]   rto;
   logic [CountWidth-1:0] retries;
   logic [RtoWidth-1:0]   lim_lo;
   logic [RtoWidth-1:0]   lim_hi;
   logic [CountWidth-1:0] retx_limit;

   rtt_estimator_rto_timer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [RtoWidth-1:0] clamp_rto(input int value);
      if (value < int'(lim_lo)) begin
         return lim_lo;
      end
      if (value > int'(lim_hi)) begin
         return lim_hi;
      end
      return value[RtoWidth-1:0];
   endfunction

   function automatic rsp_type estimate_event(input req_type ev);
      int      delta;
      int      mag;
      int      wide;
      rsp_type report;
      report.give_up = 1'b0;
      case (ev.mode)
         MODE_NEW_PACKET: begin
            retries = '0;
         end
         MODE_SAMPLE: begin
            delta = int'(ev.sample_ms) - int'(srtt);
            wide = int'(srtt) + (delta >>> 3);
            srtt = wide[RtoWidth-1:0];
            mag = (delta < 0) ? -delta : delta;
            wide = int'(dev) + ((mag - int'(dev)) >>> 2);
            dev = wide[RtoWidth-1:0];
            rto = clamp_rto(int'(srtt) + 4 * int'(dev));
         end
         MODE_TIMEOUT: begin
            rto = clamp_rto(2 * int'(rto));
            if (retries != 8'hFF) begin
               retries = retries + 8'd1;
            end
            report.give_up = retries > retx_limit;
         end
         default: begin
         end
      endcase
      report.rto_ms = rto;
      report.retransmit_count = retries;
      return report;
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (event_queue.size() != 0 &&
                (no_stalls || $urandom_range(99) >= StallPercent)) begin
               req_valid <= 1'b1;
               req_data  <= event_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= no_stalls || ($urandom_range(99) >= StallPercent);
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_taken  <= 1'b0;
         srtt       = SRTT_RESET;
         dev        = DEV_RESET;
         rto        = RTO_RESET;
         retries    = COUNT_RESET;
         lim_lo     = RTO_MIN_RESET;
         lim_hi     = RTO_MAX_RESET;
         retx_limit = MAX_RETX_RESET;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RTO_MIN:         lim_lo = csr_data[RtoWidth-1:0];
               CSR_RTO_MAX:         lim_hi = csr_data[RtoWidth-1:0];
               CSR_MAX_RETRANSMITS: retx_limit = csr_data[CountWidth-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            report_queue.push_back(estimate_event(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (report_queue.size() == 0) begin
               $display("%0t: unexpected response transaction, expected none actual %h",
                        $time, rsp_data);
               errors++;
            end else begin
               want = report_queue.pop_front();
               check_field("rto_ms", int'(want.rto_ms), int'(rsp_data.rto_ms));
               check_field("give_up", int'(want.give_up), int'(rsp_data.give_up));
               check_field("retransmit_count", int'(want.retransmit_count),
                           int'(rsp_data.retransmit_count));
            end
         end
         if ((csr_valid && csr_ready) || (req_valid && req_ready) ||
             (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_event(input logic [1:0] mode, input logic [SampleWidth-1:0] sample);
      req_type ev;
      ev.mode = mode;
      ev.sample_ms = sample;
      event_queue.push_back(ev);
   endtask

   task automatic add_random_events(input int count, input int centre);
      int                     pick;
      int                     shape;
      logic [1:0]             mode;
      logic [SampleWidth-1:0] sample;
      for (int i = 0; i < count; i++) begin
         pick  = $urandom_range(99);
         shape = $urandom_range(9);
         if (shape < 6) begin
            sample = SampleWidth'(centre / 2 + $urandom_range(centre));
         end else if (shape < 8) begin
            sample = SampleWidth'($urandom_range(65535));
         end else if (shape == 8) begin
            sample = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         end else begin
            sample = SampleWidth'($urandom_range(50));
         end
         if (pick < 15) begin
            mode = MODE_NEW_PACKET;
         end else if (pick < 55) begin
            mode = MODE_SAMPLE;
         end else if (pick < 80) begin
            mode = MODE_TIMEOUT;
         end else begin
            mode = MODE_QUERY;
         end
         add_event(mode, sample);
      end
   endtask

   task automatic new_limits();
      logic [RtoWidth-1:0] lo;
      logic [RtoWidth-1:0] hi;
      case ($urandom_range(3))
         0: lo = 16'd1;
         1: lo = RtoWidth'($urandom_range(2000));
         2: lo = RtoWidth'($urandom_range(65535));
         default: lo = 16'd0;
      endcase
      case ($urandom_range(3))
         0: hi = 16'hFFFF;
         1: hi = (lo > 16'd57535) ? 16'hFFFF : lo + RtoWidth'($urandom_range(8000));
         2: hi = RtoWidth'($urandom_range(65535));
         default: hi = RtoWidth'($urandom_range(lo));
      endcase
      write_csr(CSR_RTO_MIN, lo);
      write_csr(CSR_RTO_MAX, hi);
      write_csr(CSR_MAX_RETRANSMITS,
                CsrDataWidth'(($urandom_range(255) << 8) | $urandom_range(254)));
      if ($urandom_range(1)) begin
         write_csr(CSR_SPARE, CsrDataWidth'($urandom_range(65535)));
      end
   endtask

   task automatic settle();
      while (event_queue.size() != 0 || req_valid || report_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      add_event(MODE_QUERY, 16'hFFFF);
      add_event(MODE_NEW_PACKET, 16'h0000);
      add_event(MODE_SAMPLE, 16'h0000);
      add_event(MODE_SAMPLE, 16'hFFFF);
      add_event(MODE_SAMPLE, 16'hFFFF);
      add_event(MODE_SAMPLE, 16'h0000);
      add_event(MODE_SAMPLE, 16'd400);
      repeat (14) add_event(MODE_TIMEOUT, 16'h5555);
      add_event(MODE_QUERY, 16'hAAAA);
      add_event(MODE_NEW_PACKET, 16'hFFFF);
      add_event(MODE_QUERY, 16'h0000);
      settle();

      // A zero lower limit lets the timeout decay to zero; any timeout gives up.
      write_csr(CSR_RTO_MIN, 16'd0);
      write_csr(CSR_RTO_MAX, 16'hFFFF);
      write_csr(CSR_MAX_RETRANSMITS, 16'h0000);
      write_csr(CSR_SPARE, 16'h1234);
      repeat (40) add_event(MODE_SAMPLE, 16'h0000);
      repeat (2) add_event(MODE_TIMEOUT, 16'h0000);
      add_random_events(260, 300);
      settle();

      write_csr(CSR_RTO_MIN, 16'd5000);
      write_csr(CSR_RTO_MAX, 16'd100);
      add_random_events(200, 3000);
      settle();

      // A long run of timeouts saturates the retransmit count, with no stalls.
      write_csr(CSR_RTO_MIN, 16'd1);
      write_csr(CSR_RTO_MAX, 16'hFFFF);
      write_csr(CSR_MAX_RETRANSMITS, 16'hFFFE);
      no_stalls = 1'b1;
      add_event(MODE_NEW_PACKET, 16'h0000);
      for (int i = 0; i < 300; i++) begin
         if (i % 10 == 9) begin
            add_event((i % 20 == 19) ? MODE_SAMPLE : MODE_QUERY,
                      SampleWidth'($urandom_range(65535)));
         end else begin
            add_event(MODE_TIMEOUT, SampleWidth'($urandom_range(65535)));
         end
      end
      settle();
      no_stalls = 1'b0;

      for (int phase = 0; phase < 5; phase++) begin
         new_limits();
         add_random_events(180, $urandom_range(20, 4000));
         settle();
      end

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
